/* design/lcsl_pkg.sv */
`default_nettype none

package lcsl_pkg;

  // fixed field widths
  localparam int TAG_W     = 48;  // default tag width
  localparam int WAY_OUT_W = 3;   // reported way number
  localparam int CFG_W     = 4;   // ways_enabled register
  localparam int AGE_W     = 3;
  localparam int WAYS_DEF  = 8;

  localparam logic [AGE_W-1:0] AGE_MAX      = '1;
  localparam logic [CFG_W-1:0] WAYS_EN_RST  = 4'd8;

  // controller -> datapath
  typedef struct packed {
    logic ld_tag;   // capture incoming tag
    logic cmp;      // register per-way tag matches
    logic upd;      // commit set update and load result
    logic cfg_wr;   // write ways_enabled
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free; // result register can take a word this cycle
  } sts_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

endpackage

`default_nettype wire

/* design/lcsl_ctrl.sv */
`default_nettype none

module lcsl_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire lcsl_pkg::sts_t sts,
  output lcsl_pkg::cmd_t      cmd
);

  lcsl_pkg::state_t state_r, state_nxt;

  assign in_stall  = (state_r != lcsl_pkg::S_IDLE);
  assign cfg_ready = (state_r == lcsl_pkg::S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.cfg_wr = cfg_valid && cfg_ready;
    case (state_r)
      lcsl_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.ld_tag = 1'b1;
          state_nxt  = lcsl_pkg::S_CMP;
        end
      end
      lcsl_pkg::S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = lcsl_pkg::S_UPD;
      end
      lcsl_pkg::S_UPD: begin
        // hold until the result slot drains
        if (sts.out_free) begin
          cmd.upd   = 1'b1;
          state_nxt = lcsl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lcsl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcsl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/lcsl_dp.sv */
`default_nettype none

module lcsl_dp #(
  parameter int WAYS     = lcsl_pkg::WAYS_DEF,
  parameter int TAG_BITS = lcsl_pkg::TAG_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lcsl_pkg::cmd_t                cmd,
  output lcsl_pkg::sts_t                     sts,
  input  wire logic [TAG_BITS-1:0]           in_tag,
  input  wire logic [lcsl_pkg::CFG_W-1:0]    cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_hit,
  output logic [lcsl_pkg::WAY_OUT_W-1:0]     out_way
);

  localparam int WI_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W = lcsl_pkg::AGE_W;
  localparam int NAGES = 1 << AGE_W;

  logic [TAG_BITS-1:0]         tag_r;
  logic [TAG_BITS-1:0]         way_tag_r   [WAYS];
  logic [WAYS-1:0]             way_valid_r, way_valid_nxt;
  logic [AGE_W-1:0]            way_age_r   [WAYS];
  logic [AGE_W-1:0]            way_age_nxt [WAYS];
  logic [WAYS-1:0]             match_r;
  logic [lcsl_pkg::CFG_W-1:0]  ways_en_r;
  logic [lcsl_pkg::CFG_W-1:0]  n_eff;
  logic [WAYS-1:0]             en;

  logic                        out_valid_r;
  logic                        out_hit_r;
  logic [lcsl_pkg::WAY_OUT_W-1:0] out_way_r;

  logic                        hit;
  logic [WI_W-1:0]             hit_idx;
  logic                        any_emp;
  logic [WI_W-1:0]             emp_idx;
  logic [NAGES-1:0]            age_seen;
  logic [AGE_W-1:0]            max_age;
  logic [WI_W-1:0]             old_idx;
  logic [WI_W-1:0]             sel;
  logic [AGE_W-1:0]            hit_age;

  // 0 acts as 1; counts above WAYS simply enable every way
  assign n_eff = (ways_en_r == '0) ? lcsl_pkg::CFG_W'(1) : ways_en_r;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      en[w] = (w < int'(n_eff));
    end
  end

  // selection
  always_comb begin
    hit      = |match_r;
    hit_idx  = '0;
    any_emp  = 1'b0;
    emp_idx  = '0;
    age_seen = '0;
    max_age  = '0;
    old_idx  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (match_r[w]) hit_idx = WI_W'(w);   // highest match wins
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (en[w] && !way_valid_r[w]) begin
        any_emp = 1'b1;
        emp_idx = WI_W'(w);                  // lowest empty wins
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      for (int a = 0; a < NAGES; a++) begin
        if (en[w] && way_valid_r[w] && (int'(way_age_r[w]) == a)) age_seen[a] = 1'b1;
      end
    end
    for (int a = 0; a < NAGES; a++) begin
      if (age_seen[a]) max_age = AGE_W'(a);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (en[w] && (way_age_r[w] == max_age)) old_idx = WI_W'(w); // lowest oldest
    end
    if (hit) begin
      sel = hit_idx;
    end else if (any_emp) begin
      sel = emp_idx;
    end else begin
      sel = old_idx;
    end
  end

  assign hit_age = way_age_r[hit_idx];

  // age and valid update
  always_comb begin
    way_valid_nxt = way_valid_r;
    for (int w = 0; w < WAYS; w++) begin
      way_age_nxt[w] = way_age_r[w];
      if (WI_W'(w) == sel) begin
        way_age_nxt[w] = '0;
        way_valid_nxt[w] = 1'b1;
      end else if (en[w] && way_valid_r[w] && (!hit || (way_age_r[w] < hit_age))) begin
        if (way_age_r[w] != lcsl_pkg::AGE_MAX) begin
          way_age_nxt[w] = way_age_r[w] + AGE_W'(1);
        end
      end
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      way_valid_r <= '0;
      out_valid_r <= 1'b0;
      ways_en_r   <= lcsl_pkg::WAYS_EN_RST;
      for (int w = 0; w < WAYS; w++) begin
        way_age_r[w] <= '0;
      end
    end else begin
      if (cmd.cfg_wr) ways_en_r <= cfg_data;
      if (cmd.upd) begin
        way_valid_r <= way_valid_nxt;
        way_age_r   <= way_age_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_tag) tag_r <= in_tag;
    if (cmd.cmp) begin
      for (int w = 0; w < WAYS; w++) begin
        match_r[w] <= en[w] && way_valid_r[w] && (way_tag_r[w] == tag_r);
      end
    end
    if (cmd.upd) begin
      if (!hit) way_tag_r[sel] <= tag_r;
      out_hit_r <= hit;
      out_way_r <= lcsl_pkg::WAY_OUT_W'(sel);
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_way   = out_way_r;

endmodule

`default_nettype wire

/* design/lru_cache_set_lookup.sv */
`default_nettype none

// Channel   Direction  Handshake            Word
// in_       in         in_valid/in_stall    in_tag   (TAG_BITS)
// out_      out        out_valid/out_stall  out_hit, out_way (3)
// cfg_      in         cfg_valid/cfg_ready  cfg_data (ways_enabled, 4)
//
// Each access captures the tag, registers the per-way compares, then picks the
// way and updates valid bits, ages and, on a miss, the tag in one step.
// The three-state controller sequences these steps; a new word is taken once idle.
// rst_n is synchronous: all ways invalid, ages 0, ways_enabled = 8.
// A stalled result holds in the output register; the update step waits for it.
// cfg_ready is high only while idle.

module lru_cache_set_lookup #(
  parameter int WAYS     = lcsl_pkg::WAYS_DEF,
  parameter int TAG_BITS = lcsl_pkg::TAG_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [TAG_BITS-1:0]           in_tag,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_hit,
  output logic [lcsl_pkg::WAY_OUT_W-1:0]     out_way,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lcsl_pkg::CFG_W-1:0]    cfg_data
);

  lcsl_pkg::cmd_t cmd;   // controller commands
  lcsl_pkg::sts_t sts;   // datapath status

  // sequencer: idle -> compare -> update
  lcsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // tag store, valid bits, ages, victim choice and result register
  lcsl_dp #(
    .WAYS     (WAYS),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tag    (in_tag),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_hit   (out_hit),
    .out_way   (out_way)
  );

endmodule

`default_nettype wire
